// File: hw/rtl/mtsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtsi_pkg;

  // Sector table geometry.
  localparam int SectorSlots = 16;
  localparam int SlotW       = $clog2(SectorSlots);
  localparam int RamDepth    = 2 * SectorSlots;
  localparam int RamAddrW    = $clog2(RamDepth);

  // Track geometry: the position counter must be able to hold TrackWords itself.
  localparam int TrackWords = 16384;
  localparam int PosW       = $clog2(TrackWords + 1);
  localparam int OffW       = 14;

  // Field widths.
  localparam int WordW     = 16;
  localparam int TrackW    = 8;
  localparam int LimitW    = 5;
  localparam int CfgDataW  = 8;
  localparam int OutFieldW = SlotW + OffW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // Format constants.
  localparam logic [WordW-1:0]  SyncWord   = 16'h4489;
  localparam logic [31:0]       BitMask    = 32'h5555_5555;
  localparam logic [7:0]        FormatByte = 8'hff;
  localparam logic [SlotW-1:0]  LastSlot   = SlotW'(SectorSlots - 1);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CfgExpectedTrack = 1'b0,
    CfgSectorLimit   = 1'b1
  } cfg_idx_e;

  // Table write from the scanner.
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [SlotW-1:0] slot;
    logic [OffW-1:0]  off;
  } tbl_wr_t;

  // Table read from the dump sequencer; a read also clears the entry.
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [SlotW-1:0] slot;
  } tbl_rd_t;

endpackage

`default_nettype wire

// File: hw/rtl/mtsi_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mtsi_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port; read data holds without a read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mtsi_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module mtsi_scan import mtsi_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire logic [WordW-1:0]       word_i,
  input  wire logic                   eot_i,
  input  wire logic [TrackW-1:0]      exp_track_i,
  input  wire logic [LimitW-1:0]      limit_i,
  input  wire logic [SectorSlots-1:0] slot_valid_i,
  output tbl_wr_t                     wr_o,
  output logic                        bank_o,
  output logic                        dump_start_o
);

  logic [2:0][WordW-1:0] win_q, win_d;
  logic [2:0]            mark_q, mark_d;
  logic                  prev_sync_q, prev_sync_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic                  bank_q, bank_d;

  logic                  in_track;
  logic                  is_sync;
  logic [31:0]           odd_l, even_l, dec;
  logic [7:0]            fmt, trk, sec;
  logic                  hdr_ok;

  // Header decode over the window as it stands after this word shifts in.
  always_comb begin
    in_track = pos_q < PosW'(TrackWords);
    is_sync  = word_i == SyncWord;
    odd_l    = {win_q[0], win_q[1]};
    even_l   = {win_q[2], word_i};
    dec      = (even_l & BitMask) | ((odd_l & BitMask) << 1);
    fmt      = dec[31:24];
    trk      = dec[23:16];
    sec      = dec[15:8];
    hdr_ok   = mark_q[0] && (pos_q >= PosW'(3)) && (fmt == FormatByte) &&
               (trk == exp_track_i) && (sec < {3'b000, limit_i}) &&
               (sec[7:SlotW] == '0);
  end

  // Only the first header of each sector is written into the table.
  always_comb begin
    wr_o.en   = accept_i && in_track && hdr_ok && !slot_valid_i[sec[SlotW-1:0]];
    wr_o.bank = bank_q;
    wr_o.slot = sec[SlotW-1:0];
    wr_o.off  = OffW'(pos_q - PosW'(3));
  end

  // Window shift, sync tracking and the end-of-track clear with bank swap.
  always_comb begin
    win_d       = win_q;
    mark_d      = mark_q;
    prev_sync_d = prev_sync_q;
    pos_d       = pos_q;
    bank_d      = bank_q;
    if (accept_i) begin
      if (eot_i) begin
        win_d       = '0;
        mark_d      = '0;
        prev_sync_d = 1'b0;
        pos_d       = '0;
        bank_d      = !bank_q;
      end else if (in_track) begin
        win_d       = {word_i, win_q[2], win_q[1]};
        mark_d      = {prev_sync_q && !is_sync, mark_q[2], mark_q[1]};
        prev_sync_d = is_sync;
        pos_d       = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      mark_q      <= '0;
      prev_sync_q <= 1'b0;
      pos_q       <= '0;
      bank_q      <= 1'b0;
    end else begin
      win_q       <= win_d;
      mark_q      <= mark_d;
      prev_sync_q <= prev_sync_d;
      pos_q       <= pos_d;
      bank_q      <= bank_d;
    end
  end

  assign bank_o       = bank_q;
  assign dump_start_o = accept_i && eot_i;

endmodule

`default_nettype wire

// File: hw/rtl/mtsi_dump.sv
`timescale 1ns / 1ps
`default_nettype none

module mtsi_dump import mtsi_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic                start_bank_i,
  input  wire logic                slot_valid_i,
  input  wire logic [OffW-1:0]     rdata_i,
  input  wire logic                out_ready_i,
  output tbl_rd_t                  rd_o,
  output logic                     busy_o,
  output logic                     out_valid_o,
  output logic [SlotW-1:0]         out_slot_o,
  output logic [OffW-1:0]          out_off_o,
  output logic                     out_last_o
);

  logic             busy_q, busy_d;
  logic             bank_q, bank_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             pend_q, pend_d;
  logic             pend_vld_q, pend_vld_d;
  logic [SlotW-1:0] pend_slot_q, pend_slot_d;
  logic             oval_q, oval_d;
  logic [SlotW-1:0] oslot_q, oslot_d;
  logic [OffW-1:0]  ooff_q, ooff_d;

  logic             move;
  logic             issue;

  // Read data moves on when the output register is empty or being taken.
  assign move  = pend_q && (!oval_q || out_ready_i);
  assign issue = busy_q && (!pend_q || move);

  assign rd_o.en   = issue;
  assign rd_o.bank = bank_q;
  assign rd_o.slot = slot_q;

  // Slot sequencer, read stage and output register.
  always_comb begin
    busy_d      = busy_q;
    bank_d      = bank_q;
    slot_d      = slot_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    oval_d      = oval_q;
    oslot_d     = oslot_q;
    ooff_d      = ooff_q;

    if (move) begin
      oval_d  = 1'b1;
      oslot_d = pend_slot_q;
      ooff_d  = pend_vld_q ? rdata_i : '0;
    end else if (out_ready_i) begin
      oval_d = 1'b0;
    end

    if (issue) begin
      pend_d      = 1'b1;
      pend_vld_d  = slot_valid_i;
      pend_slot_d = slot_q;
      slot_d      = slot_q + SlotW'(1);
      if (slot_q == LastSlot) begin
        busy_d = 1'b0;
      end
    end else if (move) begin
      pend_d = 1'b0;
    end

    if (start_i) begin
      busy_d = 1'b1;
      bank_d = start_bank_i;
      slot_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bank_q <= 1'b0;
      slot_q <= '0;
      pend_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      bank_q <= bank_d;
      slot_q <= slot_d;
      pend_q <= pend_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_vld_q  <= pend_vld_d;
    pend_slot_q <= pend_slot_d;
    oslot_q     <= oslot_d;
    ooff_q      <= ooff_d;
  end

  assign busy_o      = busy_q;
  assign out_valid_o = oval_q;
  assign out_slot_o  = oslot_q;
  assign out_off_o   = ooff_q;
  assign out_last_o  = oslot_q == LastSlot;

endmodule

`default_nettype wire

// File: hw/rtl/mfm_track_sector_indexer.sv
// Flow: after the end-of-track word the dump sequencer reads each slot from the table RAM
// and passes it on through its output register, one entry per cycle while the output accepts.
// Throughput: one word per cycle while tready is high. The table is double-banked in one
// RAM, so a new track is scanned while the previous one is read out; an end-of-track word
// waits only while the sixteen slot reads of the previous dump are still being issued.
// Reset: asynchronous, active low; control state clears, expected_track 0, sector_limit 11.
`timescale 1ns / 1ps
`default_nettype none

module mfm_track_sector_indexer import mtsi_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port.
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // Input stream.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [WordW-1:0]    s_axis_tdata,   // [15:0] mfm_word
  input  wire logic                s_axis_tlast,   // end_of_track
  // Output stream.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // [3:0] sector_number, [17:4] word_offset
  output logic                     m_axis_tlast    // last_entry
);

  logic [TrackW-1:0]   exp_track_q;
  logic [LimitW-1:0]   limit_q;
  logic [RamDepth-1:0] valid_q, valid_d;

  logic                accept;
  logic                dump_busy;
  logic                dump_start;
  logic                cur_bank;
  tbl_wr_t             wr;
  tbl_rd_t             rd;
  logic [OffW-1:0]     rdata;
  logic [SlotW-1:0]    out_slot;
  logic [OffW-1:0]     out_off;

  // An end-of-track transfer waits until the previous dump has issued all reads.
  assign s_axis_tready = !(dump_busy && s_axis_tlast);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_track_q <= '0;
      limit_q     <= LimitW'(11);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgExpectedTrack: exp_track_q <= cfg_data_i[TrackW-1:0];
        CfgSectorLimit:   limit_q     <= cfg_data_i[LimitW-1:0];
        default:          ;
      endcase
    end
  end

  // Per-entry valid bits: set on the first header of a sector, cleared as the dump reads.
  always_comb begin
    valid_d = valid_q;
    if (rd.en) begin
      valid_d[{rd.bank, rd.slot}] = 1'b0;
    end
    if (wr.en) begin
      valid_d[{wr.bank, wr.slot}] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  mtsi_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .word_i       (s_axis_tdata),
    .eot_i        (s_axis_tlast),
    .exp_track_i  (exp_track_q),
    .limit_i      (limit_q),
    .slot_valid_i (valid_q[{cur_bank, {SlotW{1'b0}}} +: SectorSlots]),
    .wr_o         (wr),
    .bank_o       (cur_bank),
    .dump_start_o (dump_start)
  );

  mtsi_ram #(
    .Width (OffW),
    .Depth (RamDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i ({wr.bank, wr.slot}),
    .wdata_i (wr.off),
    .re_i    (rd.en),
    .raddr_i ({rd.bank, rd.slot}),
    .rdata_o (rdata)
  );

  mtsi_dump u_dump (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (dump_start),
    .start_bank_i (cur_bank),
    .slot_valid_i (valid_q[{rd.bank, rd.slot}]),
    .rdata_i      (rdata),
    .out_ready_i  (m_axis_tready),
    .rd_o         (rd),
    .busy_o       (dump_busy),
    .out_valid_o  (m_axis_tvalid),
    .out_slot_o   (out_slot),
    .out_off_o    (out_off),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {(OutDataW - OutFieldW)'(0), out_off, out_slot};

`ifndef SYNTHESIS
  // A new dump never starts while the previous one is still issuing reads.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_start |-> !dump_busy)
    else $error("end-of-track accepted during a dump");

  // The scanner and the dump never touch the same bank in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.en && rd.en) |-> (wr.bank != rd.bank))
    else $error("table write and dump read hit the same bank");

  // The final entry of a dump always describes the last slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (out_slot == LastSlot))
    else $error("last entry flagged on the wrong slot");

  // A started dump holds busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_start |=> dump_busy)
    else $error("dump did not start");
`endif

endmodule

`default_nettype wire

// File: tb/mfm_sector_index_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both streams of the sector indexer.
// It keeps its own copy of the track scanner and predicts every table entry.
module mfm_sector_index_checker import mtsi_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tready,
  input  wire logic [WordW-1:0]    s_axis_tdata,   // [15:0] mfm_word
  input  wire logic                s_axis_tlast,   // end_of_track
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic [OutDataW-1:0] m_axis_tdata,   // [3:0] sector_number, [17:4] word_offset
  input  wire logic                m_axis_tlast,   // last_entry
  output int unsigned              mismatches_o,
  output int unsigned              entries_due_o,
  output int unsigned              words_scanned_o,
  output int unsigned              tracks_dumped_o,
  output int unsigned              entries_checked_o,
  output int unsigned              slots_filled_o
);

  localparam int DumpEntries = (SectorSlots < 16) ? SectorSlots : 16;

  typedef struct packed {
    logic [SlotW-1:0] sector;
    logic [OffW-1:0]  offset;
    logic             last;
  } table_entry_t;

  // Settings as last written on the configuration port.
  logic [TrackW-1:0] track_sel;
  logic [LimitW-1:0] sector_limit;

  // Scanner state for the track in progress.
  logic [WordW-1:0] window [4];
  logic             start_mark [4];
  logic             prev_sync;
  int unsigned      word_pos;
  logic [OffW-1:0]  offset_tbl [SectorSlots];

  // Table entries predicted but not yet seen on the output stream.
  table_entry_t sector_entries_due [$];

  task automatic clear_scan();
    int k;
    for (k = 0; k < 4; k++) begin
      window[k]     = '0;
      start_mark[k] = 1'b0;
    end
    prev_sync = 1'b0;
    word_pos  = 0;
    for (k = 0; k < SectorSlots; k++) begin
      offset_tbl[k] = '0;
    end
  endtask

  // Decodes the four window words as a header and records its offset if it qualifies.
  task automatic try_sector_header(input int unsigned start);
    logic [31:0] odd_l;
    logic [31:0] even_l;
    logic [31:0] decoded;
    logic [7:0]  fmt_b;
    logic [7:0]  trk_b;
    logic [7:0]  sec_b;
    odd_l   = {window[0], window[1]};
    even_l  = {window[2], window[3]};
    decoded = (even_l & BitMask) | ((odd_l & BitMask) << 1);
    fmt_b   = decoded[31:24];
    trk_b   = decoded[23:16];
    sec_b   = decoded[15:8];
    if (fmt_b == FormatByte && trk_b == track_sel && sec_b < sector_limit &&
        int'(sec_b) < SectorSlots) begin
      if (offset_tbl[sec_b] == '0) begin
        offset_tbl[sec_b] = OffW'(start);
      end
    end
  endtask

  // Advances the scanner by one word; the end of a track queues the whole table.
  task automatic scan_track_word(input logic [WordW-1:0] w, input logic eot);
    logic         is_sync;
    table_entry_t entry;
    int           k;
    if (word_pos < TrackWords) begin
      is_sync = (w == SyncWord);
      for (k = 0; k < 3; k++) begin
        window[k]     = window[k+1];
        start_mark[k] = start_mark[k+1];
      end
      window[3]     = w;
      start_mark[3] = prev_sync && !is_sync;
      prev_sync     = is_sync;
      if (start_mark[0] && word_pos >= 3) begin
        try_sector_header(word_pos - 3);
      end
      word_pos++;
    end
    if (eot) begin
      for (k = 0; k < DumpEntries; k++) begin
        entry.sector = SlotW'(k);
        entry.offset = offset_tbl[k];
        entry.last   = (k == DumpEntries - 1);
        sector_entries_due.push_back(entry);
        if (offset_tbl[k] != '0) begin
          slots_filled_o++;
        end
      end
      tracks_dumped_o++;
      clear_scan();
    end
  endtask

  // Everything is sampled at the rising edge, when the bench-driven inputs are settled.
  always @(posedge clk_i) begin : watch
    table_entry_t got;
    table_entry_t want;
    if (!rst_ni) begin
      track_sel    = '0;
      sector_limit = LimitW'(11);
      clear_scan();
      sector_entries_due.delete();
      mismatches_o      = 0;
      words_scanned_o   = 0;
      tracks_dumped_o   = 0;
      entries_checked_o = 0;
      slots_filled_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgExpectedTrack) begin
          track_sel = cfg_data_i[TrackW-1:0];
        end else begin
          sector_limit = cfg_data_i[LimitW-1:0];
        end
      end

      // Output transfer: compare with the oldest predicted entry.
      if (m_axis_tvalid && m_axis_tready) begin
        got.sector = m_axis_tdata[SlotW-1:0];
        got.offset = m_axis_tdata[SlotW +: OffW];
        got.last   = m_axis_tlast;
        if (sector_entries_due.size() == 0) begin
          mismatches_o++;
          $display("%0t: unexpected table entry: sector %0d offset %0d last %0b",
                   $time, got.sector, got.offset, got.last);
        end else begin
          want = sector_entries_due.pop_front();
          entries_checked_o++;
          if (got != want || (m_axis_tdata >> OutFieldW) != '0) begin
            mismatches_o++;
            $display({"%0t: table entry mismatch: expected sector %0d offset %0d last %0b,",
                      " got sector %0d offset %0d last %0b pad %0h"},
                     $time, want.sector, want.offset, want.last,
                     got.sector, got.offset, got.last, m_axis_tdata >> OutFieldW);
          end
        end
      end

      // Input transfer: run the word through the scanner.
      if (s_axis_tvalid && s_axis_tready) begin
        words_scanned_o++;
        scan_track_word(s_axis_tdata, s_axis_tlast);
      end
    end
    entries_due_o = sector_entries_due.size();
  end

endmodule

// File: tb/tb_mfm_track_sector_indexer.sv
`timescale 1ns / 1ps

module tb_mfm_track_sector_indexer;
  import mtsi_pkg::*;

  localparam int HoldCycles   = 500;
  localparam int StallLimit   = 4000;
  localparam int RandomWords  = 330;
  localparam int SettleCycles = 8;
  localparam int TailCycles   = 24;

  // Pace of the output side.
  typedef enum int unsigned {
    RxAlways,
    RxCoin,
    RxSparse,
    RxCadence
  } rx_pace_e;

  // How a random track is closed.
  typedef enum int unsigned {
    EndPlain,
    EndCutHeader,
    EndOnHeader,
    EndOnSync
  } track_end_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [WordW-1:0]    s_axis_tdata;   // [15:0] mfm_word
  logic                s_axis_tlast;   // end_of_track
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [3:0] sector_number, [17:4] word_offset
  logic                m_axis_tlast;   // last_entry

  int unsigned mismatches;
  int unsigned entries_due;
  int unsigned words_scanned;
  int unsigned tracks_dumped;
  int unsigned entries_checked;
  int unsigned slots_filled;

  int unsigned       quiet_cycles;
  int unsigned       burst_left;
  int unsigned       words_sent;
  logic [TrackW-1:0] want_track;
  bit                hold_req;

  mfm_track_sector_indexer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  mfm_sector_index_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tlast      (s_axis_tlast),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tlast      (m_axis_tlast),
    .mismatches_o      (mismatches),
    .entries_due_o     (entries_due),
    .words_scanned_o   (words_scanned),
    .tracks_dumped_o   (tracks_dumped),
    .entries_checked_o (entries_checked),
    .slots_filled_o    (slots_filled)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: the run is abandoned after too long without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output side: changes pace now and then, and holds off once for a long stretch on request.
  initial begin : sink
    rx_pace_e    pace;
    int unsigned span;
    int unsigned beat;
    bit          hold_served;
    m_axis_tready = 1'b0;
    hold_served   = 1'b0;
    beat          = 0;
    @(posedge rst_ni);
    forever begin
      pace = rx_pace_e'($urandom_range(0, 3));
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(negedge clk_i);
        beat++;
        if (hold_req && !hold_served) begin
          hold_served = 1'b1;
          m_axis_tready <= 1'b0;
          repeat (HoldCycles) @(negedge clk_i);
        end
        case (pace)
          RxAlways: m_axis_tready <= 1'b1;
          RxCoin:   m_axis_tready <= 1'($urandom_range(0, 1));
          RxSparse: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:  m_axis_tready <= ((beat % 5) != 0);
        endcase
      end
    end
  end

  // Offers one word and returns after its transfer; bursts are broken by random gaps.
  task automatic push_word(input logic [WordW-1:0] w, input logic eot);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 32);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic push_syncs(input int unsigned n);
    repeat (n) push_word(SyncWord, 1'b0);
  endtask

  // Random words, with the odd sync thrown in so that junk headers get decoded too.
  task automatic push_noise(input int unsigned n);
    logic [WordW-1:0] w;
    repeat (n) begin
      w = WordW'($urandom);
      if ($urandom_range(0, 7) == 0) begin
        w = SyncWord;
      end
      push_word(w, 1'b0);
    end
  endtask

  // Encodes a header with random clock bits and sends its first n words.
  task automatic push_header(input logic [7:0] fmt, input logic [7:0] trk,
                             input logic [7:0] sec, input int unsigned n, input logic end_here);
    logic [31:0]      decoded;
    logic [31:0]      odd_l;
    logic [31:0]      even_l;
    logic [WordW-1:0] hw [4];
    int unsigned      i;
    decoded = {fmt, trk, sec, 8'($urandom_range(0, 255))};
    odd_l   = ((decoded >> 1) & BitMask) | ($urandom & ~BitMask);
    even_l  = (decoded & BitMask) | ($urandom & ~BitMask);
    // A leading sync pattern would move the header start; a clock bit breaks it.
    if (odd_l[31:16] == SyncWord) begin
      odd_l[31] = 1'b1;
    end
    hw = '{odd_l[31:16], odd_l[15:0], even_l[31:16], even_l[15:0]};
    for (i = 0; i < n; i++) begin
      push_word(hw[i], end_here && (i == n - 1));
    end
  endtask

  // Stops offering and waits until the table dump in flight has been drained.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (entries_due != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgExpectedTrack) begin
      want_track = value[TrackW-1:0];
    end
  endtask

  task automatic set_config(input logic [TrackW-1:0] trk, input logic [LimitW-1:0] lim);
    write_reg(CfgExpectedTrack, CfgDataW'(trk));
    write_reg(CfgSectorLimit, CfgDataW'(lim));
  endtask

  // New settings between tracks, with the extremes drawn often.
  task automatic random_config();
    logic [TrackW-1:0] trk;
    logic [LimitW-1:0] lim;
    case ($urandom_range(0, 3))
      0:       trk = '0;
      1:       trk = '1;
      default: trk = TrackW'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       lim = LimitW'(0);
      1:       lim = LimitW'(1);
      2:       lim = LimitW'(16);
      3:       lim = LimitW'(31);
      default: lim = LimitW'($urandom_range(2, 15));
    endcase
    set_config(trk, lim);
  endtask

  // A track of mostly well-formed headers, with noise, stray headers and broken endings.
  task automatic random_track();
    int unsigned n_hdr;
    int unsigned i;
    logic [7:0]  fmt;
    logic [7:0]  trk;
    logic [7:0]  sec;
    track_end_e  ending;
    n_hdr = $urandom_range(0, 4);
    for (i = 0; i < n_hdr; i++) begin
      fmt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : FormatByte;
      trk = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : want_track;
      sec = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 18));
      push_noise($urandom_range(0, 3));
      push_syncs(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2));
      push_header(fmt, trk, sec, 4, 1'b0);
    end
    ending = track_end_e'($urandom_range(0, 3));
    sec    = 8'($urandom_range(0, 15));
    case (ending)
      EndCutHeader: begin
        push_syncs(1);
        push_header(FormatByte, want_track, sec, $urandom_range(1, 3), 1'b1);
      end
      EndOnHeader: begin
        push_syncs(1);
        push_header(FormatByte, want_track, sec, 4, 1'b1);
      end
      EndOnSync: push_word(SyncWord, 1'b1);
      default: begin
        push_noise($urandom_range(0, 3));
        push_word(WordW'($urandom), 1'b1);
      end
    endcase
  endtask

  initial begin : stimulus
    int unsigned base_words;
    int unsigned hold_at;
    bit          hold_done;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgExpectedTrack;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    want_track    = '0;
    burst_left    = 0;
    words_sent    = 0;
    quiet_cycles  = 0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: lowest slot, slot just under the limit, slot at the limit,
    // a double sync, and a header completed by the end-of-track word.
    push_syncs(1);
    push_header(FormatByte, 8'd0, 8'd0, 4, 1'b0);
    push_syncs(2);
    push_header(FormatByte, 8'd0, 8'd10, 4, 1'b0);
    push_syncs(1);
    push_header(FormatByte, 8'd0, 8'd11, 4, 1'b0);
    push_syncs(1);
    push_header(FormatByte, 8'd0, 8'd5, 4, 1'b1);
    settle();

    // Highest track and full table: top slot, then a header cut off by the end of track.
    set_config(8'hff, LimitW'(16));
    push_syncs(1);
    push_header(FormatByte, 8'hff, 8'd15, 4, 1'b0);
    push_syncs(1);
    push_header(FormatByte, 8'hff, 8'd3, 2, 1'b1);
    settle();

    // A limit of zero rejects every header.
    set_config(8'h5a, LimitW'(0));
    push_syncs(1);
    push_header(FormatByte, 8'h5a, 8'd0, 4, 1'b1);
    settle();

    // Limit above the table: a sector past the table is dropped, the top slot is kept.
    set_config(8'ha5, LimitW'(31));
    push_syncs(1);
    push_header(FormatByte, 8'ha5, 8'd16, 4, 1'b0);
    push_syncs(1);
    push_header(FormatByte, 8'ha5, 8'd15, 4, 1'b1);
    settle();

    // Random tracks, with new settings now and then and one long hold-off downstream.
    base_words = words_sent;
    hold_at    = $urandom_range(80, 250);
    while (words_sent - base_words < RandomWords) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        random_config();
      end
      if (!hold_done && words_sent - base_words >= hold_at) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
        repeat (4) begin
          push_syncs(1);
          push_header(FormatByte, want_track, 8'($urandom_range(0, 15)), 4, 1'b0);
          push_word(WordW'($urandom), 1'b1);
        end
      end
      random_track();
    end

    settle();
    repeat (TailCycles) @(negedge clk_i);
    $display("Scanned %0d words in %0d tracks; checked %0d table entries, %0d with a header.",
             words_scanned, tracks_dumped, entries_checked, slots_filled);
    $display("Tracks 0 and 255, sector limits 0 to 31, cut-off headers and a long stall.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/mtsi_pkg.sv
hw/rtl/mtsi_ram.sv
hw/rtl/mtsi_scan.sv
hw/rtl/mtsi_dump.sv
hw/rtl/mfm_track_sector_indexer.sv
tb/mfm_sector_index_checker.sv
tb/tb_mfm_track_sector_indexer.sv
